FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the predictor RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, muted while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Implication form: antecedent holds, consequent follows on the next edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: design/tbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbp_pkg
// Sizes, reset values, codes and types of the tournament branch predictor.
// ----------------------------------------------------------------------------
package tbp_pkg;

    // Table sizes (powers of two)
    localparam int GLOBAL_ENTRIES     = 1024;
    localparam int LOCAL_HIST_ENTRIES = 1024;
    localparam int LOCAL_HIST_BITS    = 10;
    localparam int CHOOSER_ENTRIES    = 1024;
    localparam int LCNT_ENTRIES       = 1 << LOCAL_HIST_BITS;

    localparam int PC_W    = 10;
    localparam int EXT_W   = 16;  // common width for index arithmetic
    localparam int GIDX_W  = $clog2(GLOBAL_ENTRIES);
    localparam int LSLOT_W = $clog2(LOCAL_HIST_ENTRIES);
    localparam int CIDX_W  = $clog2(CHOOSER_ENTRIES);
    localparam int LHB     = LOCAL_HIST_BITS;

    localparam int GCNT_W = 2;
    localparam int LCNT_W = 3;
    localparam int CH_W   = 2;

    // Clear sweep covers the deepest table
    localparam int MAX_GL    = (GLOBAL_ENTRIES > LOCAL_HIST_ENTRIES) ?
                               GLOBAL_ENTRIES : LOCAL_HIST_ENTRIES;
    localparam int MAX_CL    = (CHOOSER_ENTRIES > LCNT_ENTRIES) ?
                               CHOOSER_ENTRIES : LCNT_ENTRIES;
    localparam int CLR_DEPTH = (MAX_GL > MAX_CL) ? MAX_GL : MAX_CL;
    localparam int CLR_W     = $clog2(CLR_DEPTH);

    // Reset values and thresholds
    localparam logic [GCNT_W-1:0] GCNT_INIT  = GCNT_W'(2);
    localparam logic [GCNT_W-1:0] GCNT_TAKEN = GCNT_W'(2);
    localparam logic [GCNT_W-1:0] GCNT_TOP   = GCNT_W'(3);
    localparam logic [LCNT_W-1:0] LCNT_INIT  = LCNT_W'(4);
    localparam logic [LCNT_W-1:0] LCNT_TAKEN = LCNT_W'(4);
    localparam logic [LCNT_W-1:0] LCNT_TOP   = LCNT_W'(7);
    localparam logic [CH_W-1:0]   CH_INIT    = CH_W'(2);
    localparam logic [CH_W-1:0]   CH_GLOBAL  = CH_W'(2);
    localparam logic [CH_W-1:0]   CH_TOP     = CH_W'(3);
    localparam logic [LHB-1:0]    LHIST_INIT = LHB'(1);

    // Request codes
    localparam logic REQ_PREDICT = 1'b0;
    localparam logic REQ_UPDATE  = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_LCNT  = 4'b0100,
        S_EXEC  = 4'b1000
    } t_state;

    // Result of one training step
    typedef struct packed {
        logic              pred;
        logic              mispred;
        logic [GCNT_W-1:0] gcnt_next;
        logic [LCNT_W-1:0] lcnt_next;
        logic [CH_W-1:0]   ch_next;
    } t_train;

endpackage

FILE: design/tbp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/tbp_train.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbp_train
// Chooses the prediction and computes the trained counter values.
// ----------------------------------------------------------------------------
module tbp_train (
    input  logic [tbp_pkg::GCNT_W-1:0] i_gcnt,
    input  logic [tbp_pkg::LCNT_W-1:0] i_lcnt,
    input  logic [tbp_pkg::CH_W-1:0]   i_ch,
    input  logic                       i_taken,
    output tbp_pkg::t_train            o_res
);

    logic w_gpred;
    logic w_lpred;
    logic w_g_ok;
    logic w_l_ok;

    assign w_gpred = (i_gcnt >= tbp_pkg::GCNT_TAKEN);
    assign w_lpred = (i_lcnt >= tbp_pkg::LCNT_TAKEN);
    assign w_g_ok  = (w_gpred == i_taken);
    assign w_l_ok  = (w_lpred == i_taken);

    always_comb begin
        o_res.pred    = (i_ch >= tbp_pkg::CH_GLOBAL) ? w_gpred : w_lpred;
        o_res.mispred = (o_res.pred != i_taken);

        o_res.gcnt_next = i_gcnt;
        if (i_taken) begin
            if (i_gcnt != tbp_pkg::GCNT_TOP) o_res.gcnt_next = i_gcnt + 1'b1;
        end else begin
            if (i_gcnt != '0) o_res.gcnt_next = i_gcnt - 1'b1;
        end

        o_res.lcnt_next = i_lcnt;
        if (i_taken) begin
            if (i_lcnt != tbp_pkg::LCNT_TOP) o_res.lcnt_next = i_lcnt + 1'b1;
        end else begin
            if (i_lcnt != '0) o_res.lcnt_next = i_lcnt - 1'b1;
        end

        // chooser moves only when exactly one side was right
        o_res.ch_next = i_ch;
        if (w_g_ok && !w_l_ok) begin
            if (i_ch != tbp_pkg::CH_TOP) o_res.ch_next = i_ch + 1'b1;
        end else if (!w_g_ok && w_l_ok) begin
            if (i_ch != '0) o_res.ch_next = i_ch - 1'b1;
        end
    end

endmodule

FILE: design/tournament_branch_predictor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tournament_branch_predictor_core
// Gshare global side, per-slot local side, per-slot chooser.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid/o_in_ready) carries a request: predict or update
// with the resolved direction. Every request gives one result transfer on
// the output channel (o_out_valid/i_out_ready): the chosen prediction from
// the state before the request, and on update the mispredict flag.
// Steps: the input transfer reads the global counter, local history and
// chooser tables; S_LCNT reads the local counter indexed by that history;
// S_EXEC writes back on update and registers the result. One request is in
// flight at a time. A new request is taken once the previous result has
// left or leaves in the same cycle.
// Reset: after i_rst_n is released the tables are swept to their reset
// values, one entry per cycle through all 1024 entries of the deepest
// table; o_in_ready stays low during the sweep.
// A stalled receiver holds the result in the output register and blocks
// further input until it is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tournament_branch_predictor_core (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_req_type,
    input  logic [tbp_pkg::PC_W-1:0] i_pc_low,
    input  logic                     i_taken,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic                     o_predicted_taken,
    output logic                     o_mispredicted
);

    tbp_pkg::t_state r_state, n_state;
    logic [tbp_pkg::CLR_W-1:0]   r_clr_idx, n_clr_idx;
    logic [tbp_pkg::GIDX_W-1:0]  r_ghist, n_ghist;
    logic                        r_upd;
    logic                        r_taken;
    logic [tbp_pkg::GIDX_W-1:0]  r_gidx;
    logic [tbp_pkg::LSLOT_W-1:0] r_lslot;
    logic [tbp_pkg::CIDX_W-1:0]  r_cidx;
    logic [tbp_pkg::LHB-1:0]     r_lidx;
    logic                        r_out_valid, n_out_valid;
    logic                        r_pred;
    logic                        r_mispred;

    logic                        w_accept;
    logic                        w_clear;
    logic                        w_wb;
    logic [tbp_pkg::EXT_W-1:0]   w_pc_ext;
    logic [tbp_pkg::EXT_W-1:0]   w_gx;
    logic [tbp_pkg::GIDX_W-1:0]  w_gidx;
    logic [tbp_pkg::LSLOT_W-1:0] w_lslot;
    logic [tbp_pkg::CIDX_W-1:0]  w_cidx;

    logic [tbp_pkg::GCNT_W-1:0]  w_gcnt_rd;
    logic [tbp_pkg::LHB-1:0]     w_lhist_rd;
    logic [tbp_pkg::LCNT_W-1:0]  w_lcnt_rd;
    logic [tbp_pkg::CH_W-1:0]    w_ch_rd;
    tbp_pkg::t_train             w_res;

    logic                        w_we;
    logic [tbp_pkg::GIDX_W-1:0]  w_g_waddr;
    logic [tbp_pkg::GCNT_W-1:0]  w_g_wdata;
    logic [tbp_pkg::LSLOT_W-1:0] w_lh_waddr;
    logic [tbp_pkg::LHB-1:0]     w_lh_wdata;
    logic [tbp_pkg::LHB-1:0]     w_lc_waddr;
    logic [tbp_pkg::LCNT_W-1:0]  w_lc_wdata;
    logic [tbp_pkg::CIDX_W-1:0]  w_c_waddr;
    logic [tbp_pkg::CH_W-1:0]    w_c_wdata;

    assign o_in_ready = (r_state == tbp_pkg::S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_clear    = (r_state == tbp_pkg::S_CLEAR);
    assign w_wb       = (r_state == tbp_pkg::S_EXEC) && (r_upd == tbp_pkg::REQ_UPDATE);

    // index arithmetic in a common width, then cut to each table
    assign w_pc_ext = tbp_pkg::EXT_W'(i_pc_low);
    assign w_gx     = w_pc_ext ^ tbp_pkg::EXT_W'(r_ghist);
    assign w_gidx   = w_gx[tbp_pkg::GIDX_W-1:0];
    assign w_lslot  = w_pc_ext[tbp_pkg::LSLOT_W-1:0];
    assign w_cidx   = w_pc_ext[tbp_pkg::CIDX_W-1:0];

    // write ports: clear sweep or update write-back
    always_comb begin
        w_we = w_clear || w_wb;
        if (w_clear) begin
            w_g_waddr  = r_clr_idx[tbp_pkg::GIDX_W-1:0];
            w_g_wdata  = tbp_pkg::GCNT_INIT;
            w_lh_waddr = r_clr_idx[tbp_pkg::LSLOT_W-1:0];
            w_lh_wdata = tbp_pkg::LHIST_INIT;
            w_lc_waddr = r_clr_idx[tbp_pkg::LHB-1:0];
            w_lc_wdata = tbp_pkg::LCNT_INIT;
            w_c_waddr  = r_clr_idx[tbp_pkg::CIDX_W-1:0];
            w_c_wdata  = tbp_pkg::CH_INIT;
        end else begin
            w_g_waddr  = r_gidx;
            w_g_wdata  = w_res.gcnt_next;
            w_lh_waddr = r_lslot;
            w_lh_wdata = {r_lidx[tbp_pkg::LHB-2:0], r_taken};
            w_lc_waddr = r_lidx;
            w_lc_wdata = w_res.lcnt_next;
            w_c_waddr  = r_cidx;
            w_c_wdata  = w_res.ch_next;
        end
    end

    tbp_ram #(.WIDTH(tbp_pkg::GCNT_W), .DEPTH(tbp_pkg::GLOBAL_ENTRIES)) u_gcnt (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_g_waddr),
        .i_wdata (w_g_wdata),
        .i_re    (w_accept),
        .i_raddr (w_gidx),
        .o_rdata (w_gcnt_rd)
    );

    tbp_ram #(.WIDTH(tbp_pkg::LHB), .DEPTH(tbp_pkg::LOCAL_HIST_ENTRIES)) u_lhist (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_lh_waddr),
        .i_wdata (w_lh_wdata),
        .i_re    (w_accept),
        .i_raddr (w_lslot),
        .o_rdata (w_lhist_rd)
    );

    // second-level read: indexed by the history just read
    tbp_ram #(.WIDTH(tbp_pkg::LCNT_W), .DEPTH(tbp_pkg::LCNT_ENTRIES)) u_lcnt (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_lc_waddr),
        .i_wdata (w_lc_wdata),
        .i_re    (r_state == tbp_pkg::S_LCNT),
        .i_raddr (w_lhist_rd),
        .o_rdata (w_lcnt_rd)
    );

    tbp_ram #(.WIDTH(tbp_pkg::CH_W), .DEPTH(tbp_pkg::CHOOSER_ENTRIES)) u_chooser (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_c_waddr),
        .i_wdata (w_c_wdata),
        .i_re    (w_accept),
        .i_raddr (w_cidx),
        .o_rdata (w_ch_rd)
    );

    tbp_train u_train (
        .i_gcnt  (w_gcnt_rd),
        .i_lcnt  (w_lcnt_rd),
        .i_ch    (w_ch_rd),
        .i_taken (r_taken),
        .o_res   (w_res)
    );

    always_comb begin
        n_state     = r_state;
        n_clr_idx   = r_clr_idx;
        n_ghist     = r_ghist;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            tbp_pkg::S_CLEAR: begin
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == tbp_pkg::CLR_W'(tbp_pkg::CLR_DEPTH - 1)) begin
                    n_state = tbp_pkg::S_IDLE;
                end
            end
            tbp_pkg::S_IDLE: begin
                if (w_accept) n_state = tbp_pkg::S_LCNT;
            end
            tbp_pkg::S_LCNT: begin
                n_state = tbp_pkg::S_EXEC;
            end
            tbp_pkg::S_EXEC: begin
                n_state     = tbp_pkg::S_IDLE;
                n_out_valid = 1'b1;
                if (w_wb) n_ghist = {r_ghist[tbp_pkg::GIDX_W-2:0], r_taken};
            end
            default: begin
                n_state = tbp_pkg::S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tbp_pkg::S_CLEAR;
            r_clr_idx   <= '0;
            r_ghist     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_ghist     <= n_ghist;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_upd   <= i_req_type;
            r_taken <= i_taken;
            r_gidx  <= w_gidx;
            r_lslot <= w_lslot;
            r_cidx  <= w_cidx;
        end
        if (r_state == tbp_pkg::S_LCNT) begin
            r_lidx <= w_lhist_rd;
        end
        if (r_state == tbp_pkg::S_EXEC) begin
            r_pred    <= w_res.pred;
            r_mispred <= (r_upd == tbp_pkg::REQ_UPDATE) && w_res.mispred;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_predicted_taken = r_pred;
    assign o_mispredicted    = r_mispred;

    // result appears only right after the S_EXEC state
    `ASSERT_CLK(a_out_after_exec, i_clk, i_rst_n,
        $rose(o_out_valid) |-> $past(r_state == tbp_pkg::S_EXEC))
    // accepted request always walks into the second-level lookup
    `ASSERT_NEXT(a_accept_to_lcnt, i_clk, i_rst_n, w_accept,
        r_state == tbp_pkg::S_LCNT)
    // no result and no input while the tables are being swept
    `ASSERT_CLK(a_clear_quiet, i_clk, i_rst_n,
        w_clear |-> (!o_out_valid && !o_in_ready))

endmodule
